@@ hdl/iebp_pkg.sv @@
// Shared types and codes for the I2C EEPROM byte port
`timescale 1ns / 1ps
`default_nettype none
package iebp_pkg;

   typedef enum logic [1:0] {
      CMD_SET_MODE = 2'd0,
      CMD_WRITE    = 2'd1,
      CMD_READ     = 2'd2
   } cmd_type;

   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_RECEIVE = 2'd1;

   localparam logic [1:0] ADDR_BYTES = 2'd2;
   localparam logic [1:0] ADDR_LOW   = 2'd1;
   localparam logic [1:0] ADDR_DONE  = 2'd0;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_req_type;

endpackage
`default_nettype wire

@@ hdl/iebp_mem.sv @@
// Byte storage: single-port write, registered read
`timescale 1ns / 1ps
`default_nettype none
module iebp_mem #(
   parameter int DEPTH = 8192,
   parameter int AW    = 13
) (
   input  wire logic               clock,
   input  wire iebp_pkg::mem_req_type mem_req,
   input  wire logic [AW-1:0]      waddr,
   input  wire logic [7:0]         wdata,
   input  wire logic [AW-1:0]      raddr,
   output logic [7:0]              rdata
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      if (mem_req.rd_en) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ hdl/iebp_ctrl.sv @@
// Bus mode, address phase and pointer control with memory requests
`timescale 1ns / 1ps
`default_nettype none
module iebp_ctrl #(
   parameter int MEM_BYTES = 8192,
   parameter int PW        = 13
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  item_take,
   input  wire logic [1:0]            cmd,
   input  wire logic [1:0]            bus_mode,
   input  wire logic [7:0]            data_byte,
   output iebp_pkg::mem_req_type      mem_req,
   output logic [PW-1:0]              waddr,
   output logic [PW-1:0]              raddr,
   output logic [7:0]                 wdata
);

   localparam logic [PW-1:0] LAST = PW'(MEM_BYTES - 1);

   logic [1:0]    mode_ff, mode_in;
   logic [1:0]    left_ff, left_in;
   logic [7:0]    high_ff, high_in;
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [1:0]    left_dec;

   function automatic logic [PW-1:0] wrap_addr(input logic [15:0] a);
      logic [24:0] rem;
      rem = 25'(a);
      for (int k = 7; k >= 0; k--) begin
         if (rem >= (25'(MEM_BYTES) << k)) begin
            rem = rem - (25'(MEM_BYTES) << k);
         end
      end
      return rem[PW-1:0];
   endfunction

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == LAST) ? '0 : p + PW'(1);
   endfunction

   assign left_dec = left_ff - 2'd1;

   always_comb begin
      mode_in       = mode_ff;
      left_in       = left_ff;
      high_in       = high_ff;
      wptr_in       = wptr_ff;
      rptr_in       = rptr_ff;
      mem_req.wr_en = 1'b0;
      mem_req.rd_en = 1'b0;
      if (item_take) begin
         unique case (iebp_pkg::cmd_type'(cmd))
            iebp_pkg::CMD_SET_MODE: begin
               mode_in = bus_mode;
               left_in = iebp_pkg::ADDR_BYTES;
            end
            iebp_pkg::CMD_WRITE: begin
               if (mode_ff != iebp_pkg::MODE_IDLE) begin
                  if (left_ff == iebp_pkg::ADDR_DONE) begin
                     if (mode_ff == iebp_pkg::MODE_RECEIVE) begin
                        mem_req.wr_en = 1'b1;
                        wptr_in       = next_ptr(wptr_ff);
                     end
                  end else begin
                     left_in = left_dec;
                     if (left_dec == iebp_pkg::ADDR_LOW) begin
                        high_in = data_byte;
                     end else if (left_dec == iebp_pkg::ADDR_DONE) begin
                        wptr_in = wrap_addr({high_ff, data_byte});
                        rptr_in = wrap_addr({high_ff, data_byte});
                     end
                  end
               end
            end
            iebp_pkg::CMD_READ: begin
               mem_req.rd_en = 1'b1;
               rptr_in       = next_ptr(rptr_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= iebp_pkg::MODE_IDLE;
         left_ff <= iebp_pkg::ADDR_DONE;
         high_ff <= '0;
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         left_ff <= left_in;
         high_ff <= high_in;
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   assign waddr = wptr_ff;
   assign raddr = rptr_ff;
   assign wdata = data_byte;

endmodule
`default_nettype wire

@@ hdl/i2c_eeprom_byte_port_unit.sv @@
// Top level of the I2C EEPROM byte port
//
// Each req item is one bus event: a mode change (req_cmd set mode with
// req_bus_mode), a byte from the master (write, req_data_byte) or a byte
// requested by the master (read). Every item yields exactly one rsp item;
// rsp_read_byte carries the stored byte for a read and zero otherwise.
// An accepted item passes through the read stage and then the output
// register to rsp_valid; one item per cycle is sustained while rsp is not
// stalled. The byte RAM (one access per item, registered read) sets the
// read stage; the output register follows it, so one item can wait at
// the output while another is taken. While the receiver stalls, rsp holds
// its item and req_stall rises once the read stage is also full.
// Reset clears mode (idle), the address phase and both pointers; the byte
// RAM is not cleared and a location reads as garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module i2c_eeprom_byte_port_unit #(
   parameter int MEM_BYTES = 8192
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_cmd,
   input  wire logic [1:0] req_bus_mode,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_byte
);

   localparam int PW = $clog2(MEM_BYTES);

   iebp_pkg::mem_req_type mem_req;
   logic [PW-1:0]         waddr;
   logic [PW-1:0]         raddr;
   logic [7:0]            wdata;
   logic [7:0]            rdata;
   logic                  item_take;
   logic                  s1_move;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_read_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_byte_ff;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign item_take = req_valid && !req_stall;

   iebp_ctrl #(
      .MEM_BYTES (MEM_BYTES),
      .PW        (PW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .item_take (item_take),
      .cmd       (req_cmd),
      .bus_mode  (req_bus_mode),
      .data_byte (req_data_byte),
      .mem_req   (mem_req),
      .waddr     (waddr),
      .raddr     (raddr),
      .wdata     (wdata)
   );

   iebp_mem #(
      .DEPTH (MEM_BYTES),
      .AW    (PW)
   ) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr   (raddr),
      .rdata   (rdata)
   );

   assign s1_valid_in  = item_take || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         s1_read_ff <= mem_req.rd_en;
      end
      if (s1_move) begin
         rsp_byte_ff <= s1_read_ff ? rdata : 8'd0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_byte_ff;

endmodule
`default_nettype wire

@@ hdl/iebp_checker.sv @@
// Port-level checks for the I2C EEPROM byte port and their binding
`timescale 1ns / 1ps
`default_nettype none
module iebp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_read_byte
);

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled while output empty");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_valid) |=> ##1 rsp_valid)
      else $error("item did not reach rsp within two cycles");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_read_byte)))
      else $error("stalled rsp item changed");

endmodule

bind i2c_eeprom_byte_port_unit iebp_checker u_iebp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_read_byte (rsp_read_byte)
);
`default_nettype wire
